/* rtl/stpt_pkg.sv */
// Package for the three-axis step pulse timer: action codes, field widths
// and the control/status structs passed between top level and axis units.
// No dependencies.
package stpt_pkg;

   localparam int unsigned TICK_BITS   = 16;
   localparam int unsigned TIME_BITS   = 32;
   localparam int unsigned FIELD_BITS  = 24;
   localparam int unsigned AXIS_BITS   = 2;
   localparam int unsigned OUT_AXES    = 3;
   localparam int unsigned REQ_DBITS   = 56;
   localparam int unsigned RSP_DBITS   = 40;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_START = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic tick;
   } axis_ctrl_type;

   typedef struct packed {
      logic step;
      logic active;
      logic left_next;
      logic dir_next;
   } axis_stat_type;

endpackage

/* rtl/stpt_axis.sv */
// One axis of the step pulse timer: step count, countdown, period and
// direction registers with their load and tick update. Uses stpt_pkg.
module stpt_axis #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  stpt_pkg::axis_ctrl_type        ctrl,
   input  logic [COUNT_BITS-1:0]          load_count,
   input  logic [COUNT_BITS-1:0]          load_period,
   input  logic                           load_dir,
   input  logic [stpt_pkg::TICK_BITS-1:0] tick_size,
   output stpt_pkg::axis_stat_type        stat
);

   localparam int unsigned CMP_BITS =
      (COUNT_BITS > stpt_pkg::TICK_BITS) ? COUNT_BITS : stpt_pkg::TICK_BITS;

   logic [COUNT_BITS-1:0] steps_ff, steps_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] period_ff, period_in;
   logic                  dir_ff, dir_in;
   logic                  active;
   logic                  fire;

   assign active = (steps_ff != '0);
   assign fire   = active && (CMP_BITS'(count_ff) < CMP_BITS'(tick_size));

   always_comb begin
      steps_in  = steps_ff;
      count_in  = count_ff;
      period_in = period_ff;
      dir_in    = dir_ff;
      if (ctrl.load) begin
         steps_in  = load_count;
         count_in  = load_period;
         period_in = load_period;
         dir_in    = load_dir;
      end else if (ctrl.tick && active) begin
         if (fire) begin
            count_in = period_ff;
            steps_in = steps_ff - COUNT_BITS'(1);
         end else begin
            count_in = count_ff - COUNT_BITS'(tick_size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff  <= '0;
         count_ff  <= '0;
         period_ff <= '0;
         dir_ff    <= 1'b0;
      end else begin
         steps_ff  <= steps_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         dir_ff    <= dir_in;
      end
   end

   always_comb begin
      stat.step      = ctrl.tick && fire;
      stat.active    = active;
      stat.left_next = (steps_in != '0);
      stat.dir_next  = dir_in;
   end

endmodule

/* rtl/three_axis_step_pulse_timer_top.sv */
// Top level of the three-axis step pulse timer: input register, axis units,
// cycle/time control and result register. Uses stpt_pkg and stpt_axis.
//
// Takes one beat per clock while not stalled and gives one result beat per
// request beat. A request is held in an input register, then all axes
// update together in a single compare/subtract/reload pass into the result
// register, so the rate is one beat per cycle unless stalled. The request
// side stalls only when the result register is full and rsp_tready is low.
// The tick_size register port is always ready.
module three_axis_step_pulse_timer_top #(
   parameter int unsigned NUM_AXES   = 3,
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] axis, [25:2] step_count, [49:26] step_period, [50] direction
   input  logic [stpt_pkg::REQ_DBITS-1:0] req_tdata,
   // [1:0] action
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] step_x, [1] step_y, [2] step_z, [3] dir_x, [4] dir_y, [5] dir_z,
   // [6] busy_res, [7] done_res, [39:8] elapsed_time
   output logic [stpt_pkg::RSP_DBITS-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [stpt_pkg::TICK_BITS-1:0] csr_data
);

   localparam int unsigned FB = stpt_pkg::FIELD_BITS;
   localparam int unsigned TB = stpt_pkg::TIME_BITS;

   logic [stpt_pkg::TICK_BITS-1:0] tick_ff;

   logic                           in_valid_ff;
   stpt_pkg::action_type           act_ff;
   logic [stpt_pkg::AXIS_BITS-1:0] axis_ff;
   logic [FB-1:0]                  count_ff;
   logic [FB-1:0]                  period_ff;
   logic                           dir_ff;
   logic                           advance;

   logic          running_ff, running_in;
   logic [TB-1:0] time_ff, time_in;
   logic [TB:0]   time_sum;

   logic                          out_valid_ff;
   logic [stpt_pkg::OUT_AXES-1:0] res_step_ff, res_step_in;
   logic [stpt_pkg::OUT_AXES-1:0] res_dir_ff, res_dir_in;
   logic                          res_busy_ff;
   logic                          res_done_ff, res_done_in;

   stpt_pkg::axis_ctrl_type ctrl [NUM_AXES];
   stpt_pkg::axis_stat_type stat [NUM_AXES];
   logic [NUM_AXES-1:0]     active_vec;
   logic [NUM_AXES-1:0]     left_vec;
   logic                    do_tick;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign do_tick    = advance && (act_ff == stpt_pkg::ACT_TICK) && running_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= stpt_pkg::TICK_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         tick_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         act_ff    <= stpt_pkg::action_type'(req_tuser);
         axis_ff   <= req_tdata[1:0];
         count_ff  <= req_tdata[25:2];
         period_ff <= req_tdata[49:26];
         dir_ff    <= req_tdata[50];
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      always_comb begin
         ctrl[a].load = advance && (act_ff == stpt_pkg::ACT_LOAD) &&
                        (a < stpt_pkg::OUT_AXES) && (32'(axis_ff) == a);
         ctrl[a].tick = do_tick;
      end

      stpt_axis #(
         .COUNT_BITS (COUNT_BITS)
      ) u_axis (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl[a]),
         .load_count  (COUNT_BITS'(count_ff)),
         .load_period (COUNT_BITS'(period_ff)),
         .load_dir    (dir_ff),
         .tick_size   (tick_ff),
         .stat        (stat[a])
      );

      assign active_vec[a] = stat[a].active;
      assign left_vec[a]   = stat[a].left_next;
   end

   for (genvar k = 0; k < stpt_pkg::OUT_AXES; k++) begin : g_out
      if (k < NUM_AXES) begin : g_have
         assign res_step_in[k] = stat[k].step;
         assign res_dir_in[k]  = stat[k].dir_next;
      end else begin : g_none
         assign res_step_in[k] = 1'b0;
         assign res_dir_in[k]  = 1'b0;
      end
   end

   assign time_sum = {1'b0, time_ff} + (TB + 1)'(tick_ff);

   always_comb begin
      running_in  = running_ff;
      time_in     = time_ff;
      res_done_in = 1'b0;
      if (advance) begin
         case (act_ff)
            stpt_pkg::ACT_START: running_in = 1'b1;
            stpt_pkg::ACT_STOP:  running_in = 1'b0;
            stpt_pkg::ACT_TICK: begin
               if (running_ff) begin
                  if (|active_vec) begin
                     time_in = time_sum[TB] ? '1 : time_sum[TB-1:0];
                  end
                  if (!(|left_vec)) begin
                     running_in  = 1'b0;
                     res_done_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         time_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
         time_ff    <= time_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_step_ff <= res_step_in;
         res_dir_ff  <= res_dir_in;
         res_busy_ff <= running_in;
         res_done_ff <= res_done_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {time_ff, res_done_ff, res_busy_ff, res_dir_ff, res_step_ff};

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_done_ff |-> !res_busy_ff)
      else $error("done reported with cycle still running");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance |=> time_ff >= $past(time_ff))
      else $error("elapsed time decreased");

   a_step_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      advance && (act_ff != stpt_pkg::ACT_TICK) |=> (res_step_ff == '0) && !res_done_ff)
      else $error("step or done on a non-tick beat");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending request beat dropped");

endmodule
